[sv/slfp_pkg.sv]
`timescale 1ns / 1ps

package slfp_pkg;

    localparam int COUNTER_WIDTH = 32;
    localparam int CNT_FIELD_W   = 32;
    localparam int BYTE_W        = 8;
    localparam int VERDICT_W     = 2;
    localparam int CFG_INDEX_W   = 2;

    localparam int M_TDATA_FIELDS_W = 4 * BYTE_W + VERDICT_W + 4 * CNT_FIELD_W;
    localparam int M_TDATA_W        = ((M_TDATA_FIELDS_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hDF;

    localparam logic [BYTE_W-1:0] RST_POSE_TYPE    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_STATE_TYPE   = 8'd2;
    localparam logic [BYTE_W-1:0] RST_POSE_LENGTH  = 8'd24;
    localparam logic [BYTE_W-1:0] RST_STATE_LENGTH = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSE_TYPE    = 2'd0,
        CFG_STATE_TYPE   = 2'd1,
        CFG_POSE_LENGTH  = 2'd2,
        CFG_STATE_LENGTH = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_SYNC    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPTED     = 2'd0,
        VERDICT_CHECKSUM_ERR = 2'd1,
        VERDICT_UNKNOWN_TYPE = 2'd2,
        VERDICT_LENGTH_ERR   = 2'd3
    } t_verdict;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef logic [COUNTER_WIDTH-1:0] t_count;

    // Zero-extend a counter to the width of its output field.
    function automatic logic [CNT_FIELD_W-1:0] cnt_zext(input t_count c);
        logic [CNT_FIELD_W-1:0] r;
        r = '0;
        r[COUNTER_WIDTH-1:0] = c;
        return r;
    endfunction

endpackage

[sv/sync_length_frame_parser_sum8.sv]
`timescale 1ns / 1ps

// Sync/type/length frame parser with an 8-bit additive checksum.
//
// Slave channel: one received serial byte per transfer on s_axis_tdata.
// Frames are sync 0xDF, type, length, payload bytes, checksum byte; the
// checksum is the wrapping 8-bit sum of type, length and payload bytes.
// Master channel: one transfer per payload byte (tuser = 0) carrying the byte
// and its index, and one per checksum byte (tuser = 1) carrying the verdict.
// Both carry the frame type/length and the four wrapping frame counters.
// Sync and header bytes, and bytes outside a frame, produce no transfer.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data.
//
// A result appears on the master side in the cycle after its byte is
// taken. Throughput: one byte per cycle; the parse state and running sum are
// updated in the same cycle as the byte, and a single output register holds
// the result. When the receiver stalls with a result pending, s_axis_tready
// drops until that result is taken; the pending result holds steady.
// Reset (synchronous, active low) clears the parser to waiting for sync,
// zeroes the counters and restores the register defaults.
module sync_length_frame_parser_sum8 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [slfp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [slfp_pkg::BYTE_W-1:0]         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: rx_byte [7:0]
    input  logic [slfp_pkg::BYTE_W-1:0]         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, lowest bit up: data_byte [7:0], byte_index [15:8],
    // frame_type [23:16], frame_length [31:24], verdict [33:32],
    // good_frame_count [65:34], checksum_error_count [97:66],
    // unknown_type_count [129:98], length_error_count [161:130],
    // zero fill [167:162]
    output logic [slfp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: result_kind [0]
    output logic                                m_axis_tuser
);

    import slfp_pkg::*;

    // Configuration registers
    logic [BYTE_W-1:0] r_pose_type, r_state_type, r_pose_length, r_state_length;

    // Parse state
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_held_type, n_held_type;
    logic [BYTE_W-1:0] r_held_length, n_held_length;
    logic [BYTE_W-1:0] r_position, n_position;
    logic [BYTE_W-1:0] r_sum, n_sum;
    t_count            r_good, n_good;
    t_count            r_cks_err, n_cks_err;
    t_count            r_unk_type, n_unk_type;
    t_count            r_len_err, n_len_err;

    // Result register
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [M_TDATA_W-1:0] r_out_data;

    logic                 in_xfer;
    logic                 res_valid;
    t_kind                res_kind;
    logic [BYTE_W-1:0]    res_byte;
    logic [BYTE_W-1:0]    res_index;
    t_verdict             res_verdict;
    logic [BYTE_W-1:0]    need_length;
    logic [BYTE_W-1:0]    pos_inc;

    // Accept while the output register is empty or being drained this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_type    <= RST_POSE_TYPE;
            r_state_type   <= RST_STATE_TYPE;
            r_pose_length  <= RST_POSE_LENGTH;
            r_state_length <= RST_STATE_LENGTH;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_POSE_TYPE:    r_pose_type    <= i_cfg_data;
                CFG_STATE_TYPE:   r_state_type   <= i_cfg_data;
                CFG_POSE_LENGTH:  r_pose_length  <= i_cfg_data;
                CFG_STATE_LENGTH: r_state_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pose check wins when both type codes are equal.
    assign need_length = (r_held_type == r_pose_type) ? r_pose_length : r_state_length;
    assign pos_inc     = r_position + 8'd1;

    always_comb begin
        n_phase       = r_phase;
        n_held_type   = r_held_type;
        n_held_length = r_held_length;
        n_position    = r_position;
        n_sum         = r_sum;
        n_good        = r_good;
        n_cks_err     = r_cks_err;
        n_unk_type    = r_unk_type;
        n_len_err     = r_len_err;
        res_valid     = 1'b0;
        res_kind      = KIND_PAYLOAD;
        res_byte      = '0;
        res_index     = '0;
        res_verdict   = VERDICT_ACCEPTED;

        if (in_xfer) begin
            case (r_phase)
                PH_SYNC: begin
                    if (s_axis_tdata == SYNC_BYTE) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_held_type = s_axis_tdata;
                    n_sum       = s_axis_tdata;
                    n_phase     = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_held_length = s_axis_tdata;
                    n_sum         = r_sum + s_axis_tdata;
                    n_position    = '0;
                    // An empty payload goes straight to the checksum byte.
                    n_phase       = (s_axis_tdata == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_sum      = r_sum + s_axis_tdata;
                    res_valid  = 1'b1;
                    res_kind   = KIND_PAYLOAD;
                    res_byte   = s_axis_tdata;
                    res_index  = r_position;
                    n_position = pos_inc;
                    if (pos_inc == r_held_length) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    res_valid = 1'b1;
                    res_kind  = KIND_VERDICT;
                    // A bad checksum hides the type check.
                    if (s_axis_tdata != r_sum) begin
                        n_cks_err   = r_cks_err + 1'b1;
                        res_verdict = VERDICT_CHECKSUM_ERR;
                    end else if (r_held_type == r_pose_type ||
                                 r_held_type == r_state_type) begin
                        if (r_held_length == need_length) begin
                            n_good      = r_good + 1'b1;
                            res_verdict = VERDICT_ACCEPTED;
                        end else begin
                            n_len_err   = r_len_err + 1'b1;
                            res_verdict = VERDICT_LENGTH_ERR;
                        end
                    end else begin
                        n_unk_type  = r_unk_type + 1'b1;
                        res_verdict = VERDICT_UNKNOWN_TYPE;
                    end
                    n_phase       = PH_SYNC;
                    n_held_length = '0;
                    n_position    = '0;
                    n_sum         = '0;
                end
                default: begin
                    // Unused phase codes: drop the byte and restart.
                    n_phase       = PH_SYNC;
                    n_held_length = '0;
                    n_position    = '0;
                    n_sum         = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC;
            r_held_type   <= '0;
            r_held_length <= '0;
            r_position    <= '0;
            r_sum         <= '0;
            r_good        <= '0;
            r_cks_err     <= '0;
            r_unk_type    <= '0;
            r_len_err     <= '0;
        end else begin
            r_phase       <= n_phase;
            r_held_type   <= n_held_type;
            r_held_length <= n_held_length;
            r_position    <= n_position;
            r_sum         <= n_sum;
            r_good        <= n_good;
            r_cks_err     <= n_cks_err;
            r_unk_type    <= n_unk_type;
            r_len_err     <= n_len_err;
        end
    end

    // Output register: load on a result, clear when drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Frame type/length come from the held header, before a verdict clears the held length.
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_kind <= res_kind;
            r_out_data <= {
                {(M_TDATA_W - M_TDATA_FIELDS_W){1'b0}},
                cnt_zext(n_len_err),
                cnt_zext(n_unk_type),
                cnt_zext(n_cks_err),
                cnt_zext(n_good),
                res_verdict,
                r_held_length,
                r_held_type,
                res_index,
                res_byte
            };
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

endmodule

[dv/sync_length_frame_parser_sum8_test.sv]
`timescale 1ns / 1ps

module sync_length_frame_parser_sum8_test;

    import slfp_pkg::*;

    // Give up after this many cycles in which no transfer happens on either side.
    localparam int IDLE_LIMIT = 1000;
    // Cap the number of printed mismatch lines.
    localparam int PRINT_CAP  = 50;

    typedef struct {
        t_kind                  kind;
        logic [BYTE_W-1:0]      data_byte;
        logic [BYTE_W-1:0]      byte_index;
        logic [BYTE_W-1:0]      frame_type;
        logic [BYTE_W-1:0]      frame_length;
        t_verdict               verdict;
        logic [CNT_FIELD_W-1:0] good_frames;
        logic [CNT_FIELD_W-1:0] checksum_errors;
        logic [CNT_FIELD_W-1:0] unknown_types;
        logic [CNT_FIELD_W-1:0] length_errors;
    } frame_result_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [BYTE_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;

    // Bytes waiting to go out on the slave side, and results the parser owes us.
    logic [BYTE_W-1:0] rx_bytes[$];
    frame_result_t     results_due[$];
    int                queued_bytes = 0;
    int                taken_bytes  = 0;
    int                mismatches   = 0;

    // Configuration mirror, starting from the reset values.
    logic [BYTE_W-1:0] reg_pose_type  = RST_POSE_TYPE;
    logic [BYTE_W-1:0] reg_state_type = RST_STATE_TYPE;
    logic [BYTE_W-1:0] reg_pose_len   = RST_POSE_LENGTH;
    logic [BYTE_W-1:0] reg_state_len  = RST_STATE_LENGTH;

    // Parser mirror.
    t_phase            ph          = PH_SYNC;
    logic [BYTE_W-1:0] cur_type    = '0;
    logic [BYTE_W-1:0] cur_len     = '0;
    logic [BYTE_W-1:0] pos         = '0;
    logic [BYTE_W-1:0] run_sum     = '0;
    t_count            cnt_good    = '0;
    t_count            cnt_cksum   = '0;
    t_count            cnt_unknown = '0;
    t_count            cnt_length  = '0;

    sync_length_frame_parser_sum8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction: snapshot of the frame state and counters as one result.
    // ------------------------------------------------------------------
    function automatic frame_result_t result_now(input t_kind kind,
                                                 input logic [BYTE_W-1:0] data_byte,
                                                 input logic [BYTE_W-1:0] byte_index,
                                                 input t_verdict verdict);
        frame_result_t r;
        r.kind            = kind;
        r.data_byte       = data_byte;
        r.byte_index      = byte_index;
        r.frame_type      = cur_type;
        r.frame_length    = cur_len;
        r.verdict         = verdict;
        r.good_frames     = CNT_FIELD_W'(cnt_good);
        r.checksum_errors = CNT_FIELD_W'(cnt_cksum);
        r.unknown_types   = CNT_FIELD_W'(cnt_unknown);
        r.length_errors   = CNT_FIELD_W'(cnt_length);
        return r;
    endfunction

    // Advance the parser mirror by one received byte and queue what it yields.
    function automatic void track_byte(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] need;
        t_verdict          v;
        case (ph)
            PH_SYNC: begin
                // Drop everything but the sync byte.
                if (c == SYNC_BYTE) ph = PH_TYPE;
            end
            PH_TYPE: begin
                cur_type = c;
                run_sum  = c;
                ph       = PH_LENGTH;
            end
            PH_LENGTH: begin
                cur_len = c;
                run_sum = run_sum + c;
                pos     = '0;
                // A zero length skips straight to the checksum byte.
                ph      = (c == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                run_sum = run_sum + c;
                results_due.push_back(result_now(KIND_PAYLOAD, c, pos, VERDICT_ACCEPTED));
                pos = pos + 8'd1;
                if (pos == cur_len) ph = PH_CHECK;
            end
            PH_CHECK: begin
                // A bad checksum hides the type; when both codes match, pose wins.
                if (c != run_sum) begin
                    cnt_cksum = cnt_cksum + 1'b1;
                    v = VERDICT_CHECKSUM_ERR;
                end else if (cur_type == reg_pose_type || cur_type == reg_state_type) begin
                    need = (cur_type == reg_pose_type) ? reg_pose_len : reg_state_len;
                    if (cur_len == need) begin
                        cnt_good = cnt_good + 1'b1;
                        v = VERDICT_ACCEPTED;
                    end else begin
                        cnt_length = cnt_length + 1'b1;
                        v = VERDICT_LENGTH_ERR;
                    end
                end else begin
                    cnt_unknown = cnt_unknown + 1'b1;
                    v = VERDICT_UNKNOWN_TYPE;
                end
                results_due.push_back(result_now(KIND_VERDICT, '0, '0, v));
                // Back to hunting for sync; the type byte is kept.
                ph      = PH_SYNC;
                cur_len = '0;
                pos     = '0;
                run_sum = '0;
            end
            default: begin
                ph      = PH_SYNC;
                cur_len = '0;
                pos     = '0;
                run_sum = '0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        if (mismatches < PRINT_CAP) $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Monitor: check every master-side transfer against the oldest prediction.
    always @(posedge i_clk) begin
        frame_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                report_error("result transfer with nothing expected");
            end else begin
                want = results_due.pop_front();
                compare_field("result_kind", 32'(m_axis_tuser), 32'(want.kind));
                compare_field("data_byte", 32'(m_axis_tdata[7:0]), 32'(want.data_byte));
                compare_field("byte_index", 32'(m_axis_tdata[15:8]), 32'(want.byte_index));
                compare_field("frame_type", 32'(m_axis_tdata[23:16]), 32'(want.frame_type));
                compare_field("frame_length", 32'(m_axis_tdata[31:24]),
                              32'(want.frame_length));
                compare_field("verdict", 32'(m_axis_tdata[33:32]), 32'(want.verdict));
                compare_field("good_frame_count", m_axis_tdata[65:34], want.good_frames);
                compare_field("checksum_error_count", m_axis_tdata[97:66],
                              want.checksum_errors);
                compare_field("unknown_type_count", m_axis_tdata[129:98],
                              want.unknown_types);
                compare_field("length_error_count", m_axis_tdata[161:130],
                              want.length_errors);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer queued bytes in bursts with random gaps in between.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_byte(s_axis_tdata);
                taken_bytes++;
            end
            // Hold the current byte until it is taken; only then advance.
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_bytes.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_bytes.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        // A quarter of bursts run straight into the next one.
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: the stall style steps through four patterns in turn, and a
    // periodic long hold-off lets the output register fill so the
    // parser has to stall its input.
    // ------------------------------------------------------------------
    int rx_cycle  = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_cycle % 2048 == 700) begin
                hold_left = 60 + $urandom_range(0, 40);
                m_axis_tready <= 1'b0;
            end else begin
                case ((rx_cycle >> 8) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_axis_tready <= ((rx_cycle % 4) != 3);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        rx_bytes.push_back(b);
        queued_bytes++;
    endtask

    // Queue a frame with random payload; optionally corrupt the checksum,
    // or cut the frame short after a number of bytes (negative: keep all).
    task automatic queue_frame(input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] flen,
                               input bit bad_sum, input int cut);
        logic [BYTE_W-1:0] frame[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                keep;
        frame = {SYNC_BYTE, ftype, flen};
        sum   = ftype + flen;
        for (int i = 0; i < flen; i++) begin
            b   = 8'($urandom);
            sum = sum + b;
            frame.push_back(b);
        end
        frame.push_back(bad_sum ? 8'(sum + 8'($urandom_range(1, 255))) : sum);
        keep = (cut < 0) ? frame.size() : cut;
        foreach (frame[i])
            if (i < keep) push_byte(frame[i]);
    endtask

    // Mostly well-formed frames aimed at the configured types and lengths,
    // the rest noise and truncated frames.
    task automatic queue_random(input int budget);
        int                limit_at;
        int                pick;
        logic [BYTE_W-1:0] ftype;
        logic [BYTE_W-1:0] flen;
        logic [BYTE_W-1:0] need;
        limit_at = queued_bytes + budget;
        while (queued_bytes < limit_at) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0: begin
                    ftype = reg_pose_type;
                    need  = reg_pose_len;
                end
                1: begin
                    ftype = reg_state_type;
                    need  = reg_state_len;
                end
                default: begin
                    ftype = 8'($urandom);
                    need  = 8'($urandom_range(0, 8));
                end
            endcase
            // Keep long frames rare so most of the run stays short.
            if ($urandom_range(0, 39) == 0)
                flen = 8'd255;
            else if ($urandom_range(0, 1) == 0 && (need <= 40 || $urandom_range(0, 7) == 0))
                flen = need;
            else
                flen = 8'($urandom_range(0, 8));
            if (pick < 80)
                queue_frame(ftype, flen, $urandom_range(0, 99) < 15, -1);
            else if (pick < 90)
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
            else
                queue_frame(ftype, flen, 1'b0, $urandom_range(1, flen + 3));
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [BYTE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_POSE_TYPE:    reg_pose_type  = value;
            CFG_STATE_TYPE:   reg_state_type = value;
            CFG_POSE_LENGTH:  reg_pose_len   = value;
            CFG_STATE_LENGTH: reg_state_len  = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] pose_type,
                              input logic [BYTE_W-1:0] state_type,
                              input logic [BYTE_W-1:0] pose_len,
                              input logic [BYTE_W-1:0] state_len);
        write_reg(CFG_POSE_TYPE, pose_type);
        write_reg(CFG_STATE_TYPE, state_type);
        write_reg(CFG_POSE_LENGTH, pose_len);
        write_reg(CFG_STATE_LENGTH, state_len);
    endtask

    // Wait until every byte is taken and every result has arrived, then
    // let the output stage settle before touching the registers.
    task automatic drain();
        while (taken_bytes != queued_bytes || results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values.
        push_byte(8'h00);                                  // dropped while hunting sync
        push_byte(SYNC_BYTE); push_byte(8'd2); push_byte(8'd0); push_byte(8'd2);
        // Unknown type with all-ones bytes; checksum wraps to 0xFF.
        push_byte(SYNC_BYTE); push_byte(8'hFF); push_byte(8'd1);
        push_byte(8'hFF); push_byte(8'hFF);
        // Pose type with a wrong checksum.
        push_byte(SYNC_BYTE); push_byte(8'd1); push_byte(8'd0); push_byte(8'd0);
        // Good state frame.
        queue_frame(RST_STATE_TYPE, RST_STATE_LENGTH, 1'b0, -1);

        queue_random(400);
        drain();

        // Extremes: zero codes/lengths against all-ones ones.
        set_config(8'd0, 8'd255, 8'd0, 8'd255);
        queue_frame(8'd0, 8'd0, 1'b0, -1);
        queue_frame(8'd255, 8'd255, 1'b0, -1);
        queue_random(400);
        drain();

        // Same code for both types: the pose length must win.
        set_config(8'd7, 8'd7, 8'd3, 8'd5);
        queue_frame(8'd7, 8'd3, 1'b0, -1);
        queue_frame(8'd7, 8'd5, 1'b0, -1);
        queue_random(400);
        drain();

        set_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 12)),
                   8'($urandom_range(0, 12)));
        queue_random(400);
        drain();

        set_config(8'd255, 8'd0, 8'd255, 8'd0);
        queue_frame(8'd0, 8'd0, 1'b0, -1);
        queue_random(400);
        drain();

        if (results_due.size() != 0)
            report_error($sformatf("%0d results never arrived", results_due.size()));
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
sv/slfp_pkg.sv
sv/sync_length_frame_parser_sum8.sv
dv/sync_length_frame_parser_sum8_test.sv
